/* design/plic_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the length table for the packet length checker.
// No dependencies; the other design files but plic_checker refer to this package by scope.
package plic_pkg;

  localparam int MAX_BUFFER_BYTES_DEFAULT = 65536;

  localparam int DATA_W = 8;
  localparam int LEN_W  = 16;
  localparam int RES_W  = 32;

  // Packet identifiers with their own content checks.
  localparam logic [7:0] ID_LOGIN_PATTERN = 8'h00;
  localparam logic [7:0] ID_FF_PATTERN    = 8'h01;
  localparam logic [7:0] ID_TERMINATED    = 8'h03;
  localparam logic [7:0] ID_SUBTYPE_A     = 8'h04;
  localparam logic [7:0] ID_SUBTYPE_B     = 8'h11;
  localparam logic [7:0] ID_SUBTYPE_C     = 8'h12;

  localparam logic [7:0] PAT_ED = 8'hED;
  localparam logic [7:0] PAT_FF = 8'hFF;

  localparam logic [7:0] SUB_C_0 = 8'h24;
  localparam logic [7:0] SUB_C_1 = 8'h56;
  localparam logic [7:0] SUB_C_2 = 8'h58;
  localparam logic [7:0] SUB_C_3 = 8'hC7;

  localparam logic [7:0] SUB_B_0 = 8'h00;
  localparam logic [7:0] SUB_B_1 = 8'h01;
  localparam logic [7:0] SUB_B_2 = 8'h03;
  localparam logic [7:0] SUB_B_3 = 8'h04;

  // Minimum buffer sizes that the content checks reach into.
  localparam int NEED_LOGIN = 9;
  localparam int NEED_FF    = 5;
  localparam int NEED_SUB_A = 2;
  localparam int NEED_SUB_B = 43;
  localparam int NEED_SUB_C = 4;
  localparam int MIN_VAR    = 3;

  localparam int IDX_SUB_B = 42;
  localparam int IDX_SUB_C = 3;

  localparam logic [LEN_W-1:0] LEN_LIMIT = 16'h8000;

  localparam logic [LEN_W-1:0] LEN_TABLE [256] = '{
    16'h0068, 16'h0005, 16'h0007, 16'h8000, 16'h0002, 16'h0005, 16'h0005, 16'h0007,
    16'h000E, 16'h0005, 16'h000B, 16'h010A, 16'h8000, 16'h0003, 16'h8000, 16'h003D,
    16'h00D7, 16'h8000, 16'h8000, 16'h000A, 16'h0006, 16'h0009, 16'h0001, 16'h8000,
    16'h8000, 16'h8000, 16'h8000, 16'h0025, 16'h8000, 16'h0005, 16'h0004, 16'h0008,
    16'h0013, 16'h0008, 16'h0003, 16'h001A, 16'h0007, 16'h0014, 16'h0005, 16'h0002,
    16'h0005, 16'h0001, 16'h0005, 16'h0002, 16'h0002, 16'h0011, 16'h000F, 16'h000A,
    16'h0005, 16'h0001, 16'h0002, 16'h0002, 16'h000A, 16'h028D, 16'h8000, 16'h0008,
    16'h0007, 16'h0009, 16'h8000, 16'h8000, 16'h8000, 16'h0002, 16'h0025, 16'h8000,
    16'h00C9, 16'h8000, 16'h8000, 16'h0229, 16'h02C9, 16'h0005, 16'h8000, 16'h000B,
    16'h0049, 16'h005D, 16'h0005, 16'h0009, 16'h8000, 16'h8000, 16'h0006, 16'h0002,
    16'h8000, 16'h8000, 16'h8000, 16'h0002, 16'h000C, 16'h0001, 16'h000B, 16'h006E,
    16'h006A, 16'h8000, 16'h8000, 16'h0004, 16'h0002, 16'h0049, 16'h8000, 16'h0031,
    16'h0005, 16'h0009, 16'h000F, 16'h000D, 16'h0001, 16'h0004, 16'h8000, 16'h0015,
    16'h8000, 16'h8000, 16'h0003, 16'h0009, 16'h0013, 16'h0003, 16'h000E, 16'h8000,
    16'h001C, 16'h8000, 16'h0005, 16'h0002, 16'h8000, 16'h0023, 16'h0010, 16'h0011,
    16'h8000, 16'h0009, 16'h8000, 16'h0002, 16'h8000, 16'h000D, 16'h0002, 16'h8000,
    16'h003E, 16'h8000, 16'h0002, 16'h0027, 16'h0045, 16'h0002, 16'h8000, 16'h8000,
    16'h0042, 16'h8000, 16'h8000, 16'h8000, 16'h000B, 16'h8000, 16'h8000, 16'h8000,
    16'h0013, 16'h0041, 16'h8000, 16'h0063, 16'h8000, 16'h0009, 16'h8000, 16'h0002,
    16'h8000, 16'h001A, 16'h8000, 16'h0102, 16'h0135, 16'h0033, 16'h8000, 16'h8000,
    16'h0003, 16'h0009, 16'h0009, 16'h0009, 16'h0095, 16'h8000, 16'h8000, 16'h0004,
    16'h8000, 16'h8000, 16'h0005, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h000D,
    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0040, 16'h0009, 16'h8000,
    16'h8000, 16'h0003, 16'h0006, 16'h0009, 16'h0003, 16'h8000, 16'h8000, 16'h8000,
    16'h0024, 16'h8000, 16'h8000, 16'h8000, 16'h0006, 16'h00CB, 16'h0001, 16'h0031,
    16'h0002, 16'h0006, 16'h0006, 16'h0007, 16'h8000, 16'h0001, 16'h8000, 16'h004E,
    16'h8000, 16'h0002, 16'h0019, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
    16'h8000, 16'h010C, 16'h8000, 16'h8000, 16'h0009, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0004
  };

  // Per-buffer state after the current byte has been taken.
  typedef struct packed {
    logic [7:0]       current_id;
    logic [7:0]       length_high_byte;
    logic [LEN_W-1:0] header_length;
    logic             end_byte_zero;
    logic             malformed_seen;
    logic             interesting_seen;
  } track_t;

  typedef struct packed {
    logic [7:0]       packet_id;
    logic [LEN_W-1:0] packet_length;
    logic             too_small;
    logic             bad_size;
    logic             bad_length;
    logic             malformed;
    logic             interesting;
  } result_t;

endpackage

/* design/plic_track.sv */
`timescale 1ns / 1ps
// Per-buffer state: byte count, header capture and running content checks.
// Depends on plic_pkg.
module plic_track #(
  parameter int MAX_BUFFER_BYTES = plic_pkg::MAX_BUFFER_BYTES_DEFAULT,
  parameter int CountW           = $clog2(MAX_BUFFER_BYTES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [plic_pkg::DATA_W-1:0] data_byte,
  input  logic                        last_byte,
  output logic [CountW-1:0]           byte_count_next,
  output plic_pkg::track_t            track_next
);

  logic [CountW-1:0] byte_count;
  plic_pkg::track_t  track;
  logic              take;
  logic [CountW-1:0] idx;

  assign take = byte_count < CountW'(MAX_BUFFER_BYTES);
  assign idx  = byte_count;

  always_comb begin
    track_next      = track;
    byte_count_next = byte_count;
    if (take) begin
      byte_count_next = byte_count + CountW'(1);
      if (idx == CountW'(0)) begin
        track_next.current_id = data_byte;
      end else if (idx == CountW'(1)) begin
        track_next.length_high_byte = data_byte;
      end else if (idx == CountW'(2)) begin
        track_next.header_length = {track.length_high_byte, data_byte};
      end
      case (track_next.current_id)
        plic_pkg::ID_LOGIN_PATTERN: begin
          if (idx >= CountW'(1) && idx <= CountW'(4) && data_byte != plic_pkg::PAT_ED)
            track_next.malformed_seen = 1'b1;
          if (idx >= CountW'(5) && idx <= CountW'(8) && data_byte != plic_pkg::PAT_FF)
            track_next.malformed_seen = 1'b1;
        end
        plic_pkg::ID_FF_PATTERN: begin
          if (idx >= CountW'(1) && idx <= CountW'(4) && data_byte != plic_pkg::PAT_FF)
            track_next.malformed_seen = 1'b1;
        end
        plic_pkg::ID_TERMINATED: begin
          // Remember whether the last byte within the header's length is zero.
          if (idx >= CountW'(2) && 32'(track_next.header_length) == 32'(idx) + 32'd1)
            track_next.end_byte_zero = (data_byte == 8'h00);
        end
        plic_pkg::ID_SUBTYPE_A: begin
          if (idx == CountW'(1) && data_byte > 8'h01) begin
            track_next.malformed_seen   = 1'b1;
            track_next.interesting_seen = 1'b1;
          end
        end
        plic_pkg::ID_SUBTYPE_B: begin
          if (32'(idx) == 32'(plic_pkg::IDX_SUB_B) &&
              data_byte != plic_pkg::SUB_B_0 && data_byte != plic_pkg::SUB_B_1 &&
              data_byte != plic_pkg::SUB_B_2 && data_byte != plic_pkg::SUB_B_3) begin
            track_next.malformed_seen   = 1'b1;
            track_next.interesting_seen = 1'b1;
          end
        end
        plic_pkg::ID_SUBTYPE_C: begin
          if (32'(idx) == 32'(plic_pkg::IDX_SUB_C) &&
              data_byte != plic_pkg::SUB_C_0 && data_byte != plic_pkg::SUB_C_1 &&
              data_byte != plic_pkg::SUB_C_2 && data_byte != plic_pkg::SUB_C_3) begin
            track_next.malformed_seen   = 1'b1;
            track_next.interesting_seen = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The state clears after the final byte so the next buffer starts fresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      track      <= '0;
    end else if (advance) begin
      if (last_byte) begin
        byte_count <= '0;
        track      <= '0;
      end else begin
        byte_count <= byte_count_next;
        track      <= track_next;
      end
    end
  end

endmodule

/* design/plic_verdict.sv */
`timescale 1ns / 1ps
// Final size, length and terminator checks that form the result of a buffer.
// Depends on plic_pkg.
module plic_verdict #(
  parameter int MAX_BUFFER_BYTES = plic_pkg::MAX_BUFFER_BYTES_DEFAULT,
  parameter int CountW           = $clog2(MAX_BUFFER_BYTES + 1)
) (
  input  logic [CountW-1:0]           size,
  input  plic_pkg::track_t            track,
  input  logic [plic_pkg::DATA_W-1:0] data_byte,
  output plic_pkg::result_t           result
);

  logic [plic_pkg::LEN_W-1:0] table_len;
  logic [plic_pkg::LEN_W-1:0] plen;
  logic [plic_pkg::LEN_W-1:0] clipped;
  logic                       variable_len;
  logic [31:0]                size_w;
  logic [31:0]                need;
  logic                       subtype;
  logic                       mal;
  logic                       intr;

  assign size_w       = 32'(size);
  assign table_len    = plic_pkg::LEN_TABLE[track.current_id];
  assign variable_len = table_len >= plic_pkg::LEN_LIMIT;
  assign plen         = variable_len ? track.header_length : table_len;
  // When the length exceeds the size, the size is below 2^16 and fits.
  assign clipped      = (32'(plen) > size_w) ? size_w[plic_pkg::LEN_W-1:0] : plen;

  always_comb begin
    need    = 32'd0;
    subtype = 1'b0;
    mal     = track.malformed_seen;
    intr    = track.interesting_seen;
    case (track.current_id)
      plic_pkg::ID_LOGIN_PATTERN: need = 32'(plic_pkg::NEED_LOGIN);
      plic_pkg::ID_FF_PATTERN:    need = 32'(plic_pkg::NEED_FF);
      plic_pkg::ID_SUBTYPE_A: begin
        need    = 32'(plic_pkg::NEED_SUB_A);
        subtype = 1'b1;
      end
      plic_pkg::ID_SUBTYPE_B: begin
        need    = 32'(plic_pkg::NEED_SUB_B);
        subtype = 1'b1;
      end
      plic_pkg::ID_SUBTYPE_C: begin
        need    = 32'(plic_pkg::NEED_SUB_C);
        subtype = 1'b1;
      end
      plic_pkg::ID_TERMINATED: begin
        // A terminator at or before the first byte can never be valid; a
        // length clipped by the buffer end checks the final byte instead.
        if (clipped <= 16'd1)
          mal = 1'b1;
        else if (clipped == 16'd2) begin
          if (track.length_high_byte != 8'h00) mal = 1'b1;
        end else if (clipped < plen) begin
          if (data_byte != 8'h00) mal = 1'b1;
        end else if (!track.end_byte_zero)
          mal = 1'b1;
      end
      default: begin
      end
    endcase
    if (size_w < need) begin
      mal = 1'b1;
      if (subtype) intr = 1'b1;
    end

    result           = '0;
    result.packet_id = track.current_id;
    if (variable_len && size_w < 32'(plic_pkg::MIN_VAR)) begin
      result.too_small = 1'b1;
    end else begin
      result.packet_length = plen;
      result.bad_size      = 32'(plen) != size_w;
      result.bad_length    = clipped >= plic_pkg::LEN_LIMIT;
      result.malformed     = mal;
      result.interesting   = intr;
    end
  end

endmodule

/* design/packet_length_integrity_checker_unit.sv */
`timescale 1ns / 1ps
// Top level of the packet length and integrity checker.
// Depends on plic_pkg, plic_track and plic_verdict.
//
// The block takes one byte per cycle on the slave stream, s_tlast marking the
// final byte of a received buffer, and returns one result transaction per
// buffer on the master stream once that final byte has passed the input
// register and then the result register. A byte sits in the input register,
// then the byte tracker and the verdict logic work on it combinationally and
// fill the result register, so a new byte is taken every cycle; the only
// stall comes from a result that m_tready has not yet taken while another
// final byte waits behind it. Bytes beyond MAX_BUFFER_BYTES are counted as
// neither size nor content, though the final byte still closes the buffer.
module packet_length_integrity_checker_unit #(
  parameter int MAX_BUFFER_BYTES = plic_pkg::MAX_BUFFER_BYTES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [plic_pkg::DATA_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic                        s_tlast,   // last_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [7:0] packet_id, [23:8] packet_length, [24] too_small, [25] bad_size,
  // [26] bad_length, [27] malformed, [28] interesting, [31:29] zero
  output logic [plic_pkg::RES_W-1:0]  m_tdata
);

  localparam int CountW = $clog2(MAX_BUFFER_BYTES + 1);

  logic                        in_valid;
  logic [plic_pkg::DATA_W-1:0] in_data;
  logic                        in_last;
  logic                        advance;
  logic [CountW-1:0]           byte_count_next;
  plic_pkg::track_t            track_next;
  plic_pkg::result_t           result;

  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  plic_track #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES),
    .CountW          (CountW)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .data_byte      (in_data),
    .last_byte      (in_last),
    .byte_count_next(byte_count_next),
    .track_next     (track_next)
  );

  plic_verdict #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES),
    .CountW          (CountW)
  ) u_verdict (
    .size     (byte_count_next),
    .track    (track_next),
    .data_byte(in_data),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_tdata <= {3'b000, result.interesting, result.malformed, result.bad_length,
                  result.bad_size, result.too_small, result.packet_length,
                  result.packet_id};
    end
  end

endmodule

/* design/plic_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the packet length checker, bound to its top level.
// Depends on packet_length_integrity_checker_unit.
module plic_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_too_small_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[24] |-> m_tdata[23:8] == 16'h0000 && m_tdata[28:25] == 4'h0)
    else $error("too-small result carries a length or other flags");

  a_interesting_malformed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |-> m_tdata[27] && m_tdata[31:29] == 3'b000)
    else $error("interesting without malformed, or padding set");

endmodule

bind packet_length_integrity_checker_unit plic_checker u_plic_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
